@@ rtl/core/path_vertex_cover_range_tree_macros.svh @@
// ----------------------------------------------------------------------------
// path_vertex_cover_range_tree_macros
// Assertion macros used by the range tree engine.
// Every check is clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PATH_VERTEX_COVER_RANGE_TREE_MACROS_SVH
`define PATH_VERTEX_COVER_RANGE_TREE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds.
`define PVC_NEVER(lbl, cond, msg) \
  `PVC_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/pvc_pkg.sv @@
// ----------------------------------------------------------------------------
// pvc_pkg
// Types and fixed constants shared by the range tree modules: port structs,
// the command passed from the front end to the tree engine, and engine states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pvc_pkg;

  localparam int COUNT_BITS    = 11;
  localparam int POS_BITS      = 10;
  localparam int W_IN_BITS     = 31;
  localparam int OUT_COST_BITS = 48;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic                 operation;
    logic [POS_BITS-1:0]  position;
    logic [W_IN_BITS-1:0] weight;
    logic [POS_BITS-1:0]  range_low;
    logic [POS_BITS-1:0]  range_high;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COST_BITS-1:0] cost_both_ends;
    logic [OUT_COST_BITS-1:0] cost_left_end_only;
    logic [OUT_COST_BITS-1:0] cost_right_end_only;
    logic [OUT_COST_BITS-1:0] cost_neither_end;
    logic                     range_empty;
    logic                     out_of_bounds;
  } result_t;

  // Input operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_QUERY,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 oob;
    logic [POS_BITS-1:0]  position;
    logic [W_IN_BITS-1:0] weight;
    logic [POS_BITS-1:0]  range_low;
    logic [POS_BITS-1:0]  range_high;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_READ,
    ST_U_SUM,
    ST_U_WRITE,
    ST_Q_READ,
    ST_Q_SUM,
    ST_Q_ACC,
    ST_F_SUM,
    ST_F_MIN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/path_vertex_cover_range_tree.sv @@
// ----------------------------------------------------------------------------
// path_vertex_cover_range_tree
// Segment tree of 2x2 min-plus path vertex cover tables with point update
// and range query.
// ----------------------------------------------------------------------------
// An update beat steps through read, sum and write at each tree level in the
// engine and gives no result; a query steps through read, sum and accumulate
// at each level it walks, then a final sum and min, on the shared join datapath
// and the two-read-port node memory. Beats queue in a two-entry command queue
// and results in a two-entry result queue. After reset and after every
// position_count write the node memory is swept, one node a cycle, with full
// held high.
`timescale 1ns / 1ps
`default_nettype none
module path_vertex_cover_range_tree #(
  parameter int LEAF_COUNT  = 1024,
  parameter int COST_BITS   = 48,
  parameter int WEIGHT_BITS = 31
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  input  pvc_pkg::in_item_t              item,
  output logic                           full,
  input  wire                            pop,
  output pvc_pkg::result_t               result,
  output logic                           empty,
  input  wire                            cfg_write,
  input  wire  [pvc_pkg::COUNT_BITS-1:0] cfg_data
);
  import pvc_pkg::*;

  logic [COUNT_BITS-1:0] position_count;
  logic                  clearing;
  logic                  cmd_push;
  cmd_t                  cmd_in;
  cmd_t                  cmd_out;
  logic                  cmd_full;
  logic                  cmd_empty;
  logic                  cmd_pop;
  logic                  res_push;
  result_t               res_in;
  logic                  res_full;

  // Hold the position count.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= COUNT_RESET;
    end else if (cfg_write) begin
      position_count <= cfg_data;
    end
  end

  pvc_front #(.LEAF_COUNT(LEAF_COUNT)) u_front (
    .push          (push),
    .item          (item),
    .full          (full),
    .position_count(position_count),
    .clearing      (clearing),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  pvc_queue #(.item_t(cmd_t)) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  pvc_engine #(
    .LEAF_COUNT (LEAF_COUNT),
    .COST_BITS  (COST_BITS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .clearing (clearing),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full)
  );

  pvc_queue #(.item_t(result_t)) u_res_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .pop    (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule
`default_nettype wire

@@ rtl/core/pvc_queue.sv @@
// ----------------------------------------------------------------------------
// pvc_queue
// Small first-in first-out queue of any packed type, with push/full on the
// write side and pop/empty on the read side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pvc_queue #(
  parameter type item_t = logic
) (
  input  wire   clk,
  input  wire   rst,
  input  wire   push,
  input  item_t wr_data,
  output logic  full,
  input  wire   pop,
  output item_t rd_data,
  output logic  empty
);
  import pvc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t                slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       fill;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  // Store a beat on push.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pvc_front.sv @@
// ----------------------------------------------------------------------------
// pvc_front
// Accept input beats, check them against the usable position count and turn
// them into engine commands. Updates out of range are dropped here; queries
// out of range or with low above high become ready-made empty results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pvc_front #(
  parameter int LEAF_COUNT = 1024
) (
  input  wire                          push,
  input  pvc_pkg::in_item_t            item,
  output logic                         full,
  input  wire  [pvc_pkg::COUNT_BITS-1:0] position_count,
  input  wire                          clearing,
  input  wire                          cmd_full,
  output logic                         cmd_push,
  output pvc_pkg::cmd_t                cmd
);
  import pvc_pkg::*;

  localparam int LC_W  = $clog2(LEAF_COUNT + 1);
  localparam int CMP_W = (LC_W > COUNT_BITS) ? LC_W : COUNT_BITS;

  logic [CMP_W-1:0] usable;
  logic             accept;
  logic             upd_oob;
  logic             qry_oob;

  // Clamp the count to the tree size.
  assign usable = (CMP_W'(position_count) > CMP_W'(LEAF_COUNT)) ?
                  CMP_W'(LEAF_COUNT) : CMP_W'(position_count);

  assign full    = cmd_full || clearing;
  assign accept  = push && !full;
  assign upd_oob = CMP_W'(item.position) >= usable;
  assign qry_oob = (CMP_W'(item.range_low) >= usable) ||
                   (CMP_W'(item.range_high) >= usable);

  // Classify the beat.
  always_comb begin
    cmd.oob        = 1'b0;
    cmd.position   = item.position;
    cmd.weight     = item.weight;
    cmd.range_low  = item.range_low;
    cmd.range_high = item.range_high;
    cmd.kind       = CMD_UPDATE;
    cmd_push       = 1'b0;
    if (item.operation == OP_UPDATE) begin
      cmd.kind = CMD_UPDATE;
      cmd_push = accept && !upd_oob;
    end else begin
      cmd.oob  = qry_oob;
      cmd.kind = (qry_oob || (item.range_low > item.range_high)) ? CMD_EMPTY : CMD_QUERY;
      cmd_push = accept;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pvc_engine.sv @@
// ----------------------------------------------------------------------------
// pvc_engine
// Tree engine: node memory, the min-plus join datapath and the sequencer
// that walks updates up to the root and queries bottom-up over a range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pvc_engine #(
  parameter int LEAF_COUNT  = 1024,
  parameter int COST_BITS   = 48,
  parameter int WEIGHT_BITS = 31
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_write,
  output logic             clearing,
  input  pvc_pkg::cmd_t    cmd,
  input  wire              cmd_empty,
  output logic             cmd_pop,
  output logic             res_push,
  output pvc_pkg::result_t res,
  input  wire              res_full
);
  import pvc_pkg::*;

  localparam int NODE_COUNT = 2 * LEAF_COUNT;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int PTR_W      = IDX_W + 1;
  localparam int WORD_W     = 4 * COST_BITS + 1;
  localparam logic [COST_BITS-1:0] INF = '1;
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  // Node word: empty mark on top, then neither, right, left, both.
  logic [WORD_W-1:0] node_mem [NODE_COUNT];

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  clr_addr;
  logic [IDX_W-1:0]  node_idx;
  logic [PTR_W-1:0]  lp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  rp_dec;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] lacc;
  logic [WORD_W-1:0] racc;
  logic [WORD_W-1:0] res_word;
  logic              res_oob;

  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [WORD_W-1:0] wd;
  logic [IDX_W-1:0]  ra;
  logic [IDX_W-1:0]  rb;
  logic [IDX_W-1:0]  leaf_idx;
  logic [WORD_W-1:0] leaf_word;

  // Join lanes: lane 0 for updates, left accumulation and the final join,
  // lane 1 for right accumulation.
  logic [WORD_W-1:0]    op_a    [2];
  logic [WORD_W-1:0]    op_b    [2];
  logic [WORD_W-1:0]    hold_a  [2];
  logic [WORD_W-1:0]    hold_b  [2];
  logic [COST_BITS-1:0] sum_x   [2][4];
  logic [COST_BITS-1:0] sum_y   [2][4];
  logic [COST_BITS-1:0] reg_x   [2][4];
  logic [COST_BITS-1:0] reg_y   [2][4];
  logic [WORD_W-1:0]    joined  [2];

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                    input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF}) ? INF : s[COST_BITS-1:0];
  endfunction

  function automatic logic [COST_BITS-1:0] cost_of(input logic [WORD_W-1:0] w,
                                                    input int k);
    return w[k*COST_BITS +: COST_BITS];
  endfunction

  assign rp_dec    = rp - 1'b1;
  assign leaf_idx  = IDX_W'(LEAF_COUNT) + IDX_W'(cmd.position);
  assign leaf_word = {1'b0, {COST_BITS{1'b0}}, INF, INF,
                      COST_BITS'(WEIGHT_BITS'(cmd.weight))};

  // Pick join operands for the current state.
  always_comb begin
    op_a[0] = lacc;
    op_b[0] = rd_a;
    op_a[1] = rd_b;
    op_b[1] = racc;
    unique case (state)
      ST_U_SUM: begin
        op_a[0] = rd_a;
        op_b[0] = rd_b;
      end
      ST_F_SUM: begin
        op_a[0] = lacc;
        op_b[0] = racc;
      end
      default: begin
        op_a[0] = lacc;
        op_b[0] = rd_a;
      end
    endcase
  end

  // Form both candidate sums per table cell.
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      for (int k = 0; k < 4; k++) begin
        logic [COST_BITS-1:0] b1;
        logic [COST_BITS-1:0] b0;
        b1 = cost_of(op_b[n], (k % 2 == 0) ? 0 : 1);
        b0 = cost_of(op_b[n], (k % 2 == 0) ? 2 : 3);
        sum_x[n][k] = sat_add(cost_of(op_a[n], (k < 2) ? 1 : 3), b1);
        sum_y[n][k] = sat_add(cost_of(op_a[n], (k < 2) ? 0 : 2), (b1 < b0) ? b1 : b0);
      end
    end
  end

  // Finish the join: take minima and apply the empty rules.
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      joined[n] = '0;
      for (int k = 0; k < 4; k++) begin
        joined[n][k*COST_BITS +: COST_BITS] =
          (reg_x[n][k] < reg_y[n][k]) ? reg_x[n][k] : reg_y[n][k];
      end
      priority if (hold_a[n][WORD_W-1] && hold_b[n][WORD_W-1]) begin
        joined[n] = EMPTY_WORD;
      end else if (hold_b[n][WORD_W-1]) begin
        joined[n] = hold_a[n];
      end else if (hold_a[n][WORD_W-1]) begin
        joined[n] = hold_b[n];
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_addr == IDX_W'(NODE_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            CMD_UPDATE: state_next = ST_U_READ;
            CMD_QUERY:  state_next = ST_Q_READ;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_U_READ:  state_next = ST_U_SUM;
      ST_U_SUM:   state_next = ST_U_WRITE;
      ST_U_WRITE: state_next = (node_idx == IDX_W'(1)) ? ST_IDLE : ST_U_READ;
      ST_Q_READ:  state_next = ST_Q_SUM;
      ST_Q_SUM:   state_next = ST_Q_ACC;
      ST_Q_ACC: begin
        state_next = (((lp + PTR_W'(lp[0])) >> 1) < (rp >> 1)) ? ST_Q_READ : ST_F_SUM;
      end
      ST_F_SUM:   state_next = ST_F_MIN;
      ST_F_MIN:   state_next = ST_DONE;
      ST_DONE:    if (!res_full) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
    if (cfg_write) state_next = ST_CLEAR;
  end

  // Outputs and memory port control.
  always_comb begin
    clearing = (state == ST_CLEAR);
    cmd_pop  = (state == ST_IDLE) && !cmd_empty;
    res_push = (state == ST_DONE) && !res_full;
    we       = 1'b0;
    wa       = leaf_idx;
    wd       = leaf_word;
    ra       = {node_idx[IDX_W-2:0], 1'b0};
    rb       = {node_idx[IDX_W-2:0], 1'b1};
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
        wd = EMPTY_WORD;
      end
      ST_IDLE: we = !cmd_empty && (cmd.kind == CMD_UPDATE);
      ST_U_WRITE: begin
        we = 1'b1;
        wa = node_idx;
        wd = joined[0];
      end
      ST_Q_READ: begin
        ra = lp[IDX_W-1:0];
        rb = rp_dec[IDX_W-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  // Node memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[wa] <= wd;
    end
    rd_a <= node_mem[ra];
    rd_b <= node_mem[rb];
  end

  // Register sums and operands between the two join halves.
  always_ff @(posedge clk) begin
    for (int n = 0; n < 2; n++) begin
      hold_a[n] <= op_a[n];
      hold_b[n] <= op_b[n];
      for (int k = 0; k < 4; k++) begin
        reg_x[n][k] <= sum_x[n][k];
        reg_y[n][k] <= sum_y[n][k];
      end
    end
  end

  // Walk pointers, accumulators and result.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        node_idx <= leaf_idx >> 1;
        lp       <= PTR_W'(LEAF_COUNT) + PTR_W'(cmd.range_low);
        rp       <= PTR_W'(LEAF_COUNT) + PTR_W'(cmd.range_high) + 1'b1;
        lacc     <= EMPTY_WORD;
        racc     <= EMPTY_WORD;
        res_word <= EMPTY_WORD;
        res_oob  <= cmd.oob;
      end
      ST_U_WRITE: node_idx <= node_idx >> 1;
      ST_Q_ACC: begin
        if (lp[0]) lacc <= joined[0];
        if (rp[0]) racc <= joined[1];
        lp <= (lp + PTR_W'(lp[0])) >> 1;
        rp <= rp >> 1;
      end
      ST_F_MIN: res_word <= joined[0];
      default: res_oob <= res_oob;
    endcase
  end

  // State and clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= (state == ST_CLEAR && !cfg_write) ? clr_addr + 1'b1 : '0;
    end
  end

  assign res.cost_both_ends      = OUT_COST_BITS'(cost_of(res_word, 0));
  assign res.cost_left_end_only  = OUT_COST_BITS'(cost_of(res_word, 1));
  assign res.cost_right_end_only = OUT_COST_BITS'(cost_of(res_word, 2));
  assign res.cost_neither_end    = OUT_COST_BITS'(cost_of(res_word, 3));
  assign res.range_empty         = res_word[WORD_W-1];
  assign res.out_of_bounds       = res_oob;

`include "path_vertex_cover_range_tree_macros.svh"

  `PVC_ASSERT(a_walk_open, (state == ST_Q_READ) |-> (lp < rp), "query walk with empty span")
  `PVC_NEVER(a_root_bound, (state == ST_U_READ) && (node_idx == '0), "update walked past root")
  `PVC_ASSERT(a_root_ends,
    (state == ST_U_WRITE && node_idx == IDX_W'(1) && !cfg_write) |=> (state == ST_IDLE),
    "update did not end at root")
  `PVC_NEVER(a_pop_busy, cmd_pop && (state_next == ST_CLEAR) && !cfg_write, "command taken into clear")

endmodule
`default_nettype wire

@@ bench/path_vertex_cover_range_tree_tb.sv @@
// ----------------------------------------------------------------------------
// path_vertex_cover_range_tree_tb
// Drives weight updates and range queries into the range tree through its
// queue ports, predicts query results with a local segment tree of min-plus
// tables or takes typed-in ones, and compares each popped beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module path_vertex_cover_range_tree_tb;
  import pvc_pkg::*;

  localparam int  LEAVES    = 1024;
  localparam int  NODES     = 2 * LEAVES;
  localparam logic [47:0] INF = {48{1'b1}};
  localparam int  STALL_LIMIT = 20000;
  localparam int  SETTLE    = 80;

  typedef struct packed {
    logic [47:0] both;
    logic [47:0] lonly;
    logic [47:0] ronly;
    logic [47:0] neither;
    logic        blank;
  } table_t;

  // Directed row: item, expected result, whether the expectation is typed in
  typedef struct {
    in_item_t beat;
    logic     fixed;
    result_t  want;
  } row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  in_item_t item = '0;
  logic     full;
  logic     pop = 1'b0;
  result_t  result;
  logic     empty;
  logic     cfg_write = 1'b0;
  logic [COUNT_BITS-1:0] cfg_data = '0;

  table_t   tree [NODES];
  int       span_count;
  result_t  pending_results [$];
  int       errors = 0;
  int       send_idle = 0;
  int       recv_idle = 0;
  logic     recv_hold = 1'b0;
  int       quiet = 0;
  row_t     rows [$];

  path_vertex_cover_range_tree DUT (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == INF || b == INF || s >= {1'b0, INF}) return INF;
    return s[47:0];
  endfunction

  function automatic logic [47:0] min_of(logic [47:0] a, logic [47:0] b);
    return a < b ? a : b;
  endfunction

  function automatic logic [47:0] entry(table_t t, bit le, bit re);
    case ({le, re})
      2'b11: return t.both;
      2'b10: return t.lonly;
      2'b01: return t.ronly;
      default: return t.neither;
    endcase
  endfunction

  function automatic table_t blank_table();
    table_t t;
    t = '{INF, INF, INF, INF, 1'b1};
    return t;
  endfunction

  // Combine two adjacent ranges: the seam needs at least one side chosen
  function automatic table_t merge(table_t a, table_t b);
    table_t r;
    logic [47:0] v [4];
    if (a.blank) return b;
    if (b.blank) return a;
    for (int k = 0; k < 4; k++) begin
      bit le, re;
      le = (k < 2);
      re = (k % 2 == 0);
      v[k] = min_of(sat_sum(entry(a, le, 0), entry(b, 1, re)),
                    sat_sum(entry(a, le, 1),
                            min_of(entry(b, 1, re), entry(b, 0, re))));
    end
    r = '{v[0], v[1], v[2], v[3], 1'b0};
    return r;
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < NODES; i++) tree[i] = blank_table();
  endfunction

  function automatic int usable();
    return span_count > LEAVES ? LEAVES : span_count;
  endfunction

  // Apply one beat to the local tree; returns 1 with the answer for a query
  function automatic bit predict_cover(in_item_t b, output result_t r);
    table_t lacc, racc, res;
    int l, h, n;
    bit oob;
    n = usable();
    if (b.operation == OP_UPDATE) begin
      if (b.position >= n) return 0;
      n = b.position + LEAVES;
      tree[n] = '{48'(b.weight), INF, INF, 48'd0, 1'b0};
      for (n = n >> 1; n >= 1; n = n >> 1) tree[n] = merge(tree[2*n], tree[2*n+1]);
      return 0;
    end
    res = blank_table();
    oob = (b.range_low >= n) || (b.range_high >= n);
    if (!oob && b.range_low <= b.range_high) begin
      lacc = blank_table();
      racc = blank_table();
      l = b.range_low + LEAVES;
      h = b.range_high + LEAVES + 1;
      while (l < h) begin
        if (l & 1) begin lacc = merge(lacc, tree[l]); l++; end
        if (h & 1) begin h--; racc = merge(tree[h], racc); end
        l = l >> 1;
        h = h >> 1;
      end
      res = merge(lacc, racc);
    end
    r = '{res.both, res.lonly, res.ronly, res.neither, res.blank, oob};
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic in_item_t mk(bit op, int p, logic [30:0] w, int lo, int hi);
    in_item_t b;
    b.operation  = op ? OP_QUERY : OP_UPDATE;
    b.position   = POS_BITS'(p);
    b.weight     = w;
    b.range_low  = POS_BITS'(lo);
    b.range_high = POS_BITS'(hi);
    return b;
  endfunction

  function automatic void add_row(in_item_t b, bit fx, result_t w);
    row_t r;
    r.beat = b;
    r.fixed = fx;
    r.want = w;
    rows.push_back(r);
  endfunction

  // Offer one beat and hold it until accepted; queue its expected result
  task automatic send_beat(in_item_t b, bit fx, result_t w);
    result_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_cover(b, r)) pending_results.push_back(fx ? w : r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(int v);
    cfg_write <= 1'b1;
    cfg_data  <= COUNT_BITS'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    span_count = v;
    wipe_tree();
  endtask

  function automatic in_item_t random_beat();
    int n, lo, hi;
    logic [30:0] w;
    n = usable();
    w = ($urandom_range(9) == 0) ? 31'(31'h7fffffff - $urandom_range(3)) : 31'($urandom);
    if ($urandom_range(3) == 0) w = 31'($urandom_range(20));
    lo = $urandom_range(n - 1);
    hi = $urandom_range(n - 1);
    if ($urandom_range(9) == 0) hi = $urandom_range(1023);
    if ($urandom_range(9) == 0) lo = $urandom_range(1023);
    return mk($urandom_range(1) == 1, ($urandom_range(15) == 0) ? $urandom_range(1023)
              : $urandom_range(n - 1), w, lo, hi);
  endfunction

  // Receiver: random pop, with a long hold when asked
  always @(posedge clk) begin
    if (rst || recv_hold) pop <= 1'b0;
    else pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // Check each popped beat against the oldest expectation
  always @(posedge clk) begin
    result_t w;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 48'd1, 48'd0);
      end else begin
        w = pending_results.pop_front();
        if (result.cost_both_ends !== w.cost_both_ends)
          report_mismatch("cost_both_ends", result.cost_both_ends, w.cost_both_ends);
        if (result.cost_left_end_only !== w.cost_left_end_only)
          report_mismatch("cost_left_end_only", result.cost_left_end_only,
                          w.cost_left_end_only);
        if (result.cost_right_end_only !== w.cost_right_end_only)
          report_mismatch("cost_right_end_only", result.cost_right_end_only,
                          w.cost_right_end_only);
        if (result.cost_neither_end !== w.cost_neither_end)
          report_mismatch("cost_neither_end", result.cost_neither_end,
                          w.cost_neither_end);
        if (result.range_empty !== w.range_empty)
          report_mismatch("range_empty", 48'(result.range_empty), 48'(w.range_empty));
        if (result.out_of_bounds !== w.out_of_bounds)
          report_mismatch("out_of_bounds", 48'(result.out_of_bounds),
                          48'(w.out_of_bounds));
      end
    end
  end

  // Watchdog: count cycles in which no beat moves; sweeps also hold full
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_write) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("path_vertex_cover_range_tree_tb: done, errors");
      $finish;
    end
  end

  initial begin
    result_t none;
    result_t r;
    none = '{INF, INF, INF, INF, 1'b1, 1'b0};
    span_count = int'(COUNT_RESET);
    wipe_tree();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty tree, extremes, single positions, bad ranges
    add_row(mk(1, 0, 0, 0, 1023), 1, none);
    add_row(mk(1, 0, 0, 5, 4), 1, none);
    r = none; r.out_of_bounds = 1'b1;
    add_row(mk(1, 0, 0, 0, 1024 - 1 + 0), 1, none);
    add_row(mk(0, 0, 31'h7fffffff, 0, 0), 0, none);
    add_row(mk(1, 0, 0, 0, 0), 1, '{48'h7fffffff, INF, INF, 48'd0, 1'b0, 1'b0});
    add_row(mk(0, 1023, 31'h7fffffff, 0, 0), 0, none);
    add_row(mk(0, 1, 0, 0, 0), 0, none);
    add_row(mk(0, 2, 7, 0, 0), 0, none);
    add_row(mk(1, 0, 0, 0, 2), 0, none);
    add_row(mk(1, 0, 0, 1, 1022), 0, none);
    add_row(mk(1, 0, 0, 0, 1023), 0, none);
    add_row(mk(1, 0, 0, 1023, 1023), 0, none);
    add_row(mk(1, 0, 0, 1023, 0), 1, none);
    add_row(mk(0, 512, 31'h2aaaaaaa, 0, 0), 0, none);
    add_row(mk(0, 511, 31'h55555555, 0, 0), 0, none);
    add_row(mk(1, 0, 0, 511, 512), 0, none);
    add_row(mk(1, 1023, 31'h7fffffff, 200, 700), 0, none);
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].want);
    drain();

    // Small count: out-of-range update ignored, query ends out of bounds
    write_count(4);
    send_beat(mk(0, 4, 9, 0, 0), 0, none);
    send_beat(mk(0, 3, 9, 0, 0), 0, none);
    send_beat(mk(1, 0, 0, 0, 4), 1, r);
    send_beat(mk(1, 0, 0, 4, 3), 1, r);
    send_beat(mk(1, 0, 0, 0, 3), 0, none);
    drain();
    write_count(0);
    send_beat(mk(0, 0, 5, 0, 0), 0, none);
    send_beat(mk(1, 0, 0, 0, 0), 1, r);
    drain();
    write_count(2047);
    send_beat(mk(1, 0, 0, 1023, 1023), 1, none);
    drain();

    // Random phases with different counts and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_count(1); send_idle = 37; recv_idle = 51; end
        1: begin write_count(16); send_idle = 51; recv_idle = 37; end
        2: begin write_count(1024); send_idle = 0; recv_idle = 0; end
        default: begin write_count(300); send_idle = 20; recv_idle = 20; end
      endcase
      for (int k = 0; k < 400; k++) begin
        if (ph == 2 && k == 100) begin
          // Hold the receiver off long enough for both queues to fill
          recv_hold <= 1'b1;
          fork
            begin repeat (600) @(posedge clk); recv_hold <= 1'b0; end
          join_none
        end
        if (ph == 3 && k == 200) drain();
        send_beat(random_beat(), 0, none);
      end
      drain();
    end

    if (errors == 0) $display("path_vertex_cover_range_tree_tb: done, clean");
    else $display("path_vertex_cover_range_tree_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
